/* sv/index_primitive_assembler_top_assert.svh */
// Assertion macros for the index primitive assembler.
// Included inside the top level module body; no other dependencies.
`ifndef INDEX_PRIMITIVE_ASSEMBLER_TOP_ASSERT_SVH
`define INDEX_PRIMITIVE_ASSEMBLER_TOP_ASSERT_SVH

// condition must never hold outside reset
`define IPA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

// consequent must hold in the cycle after antecedent
`define IPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ipa_pkg.sv */
// Shared constants for the index primitive assembler.
// No dependencies; used by the channel interfaces and the top level.
package ipa_pkg;

    localparam int unsigned IPA_INDEX_BITS = 16;
    localparam int unsigned TOPO_BITS      = 3;
    localparam int unsigned CFG_IDX_BITS   = 1;

    typedef logic [TOPO_BITS-1:0]    t_topology;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_topology TOPO_TRI_LIST   = 3'd0;
    localparam t_topology TOPO_TRI_FAN    = 3'd1;
    localparam t_topology TOPO_TRI_STRIP  = 3'd2;
    localparam t_topology TOPO_LINE_LIST  = 3'd3;
    localparam t_topology TOPO_LINE_STRIP = 3'd4;

    localparam t_cfg_idx CFG_TOPOLOGY     = 1'd0;
    localparam t_cfg_idx CFG_VERTEX_COUNT = 1'd1;

endpackage

/* sv/ipa_idx_if.sv */
// Index input channel: valid/ready plus one vertex index word and a last-in-batch flag.
// Depends on ipa_pkg for the default index width.
interface ipa_idx_if #(
    parameter int unsigned INDEX_BITS = ipa_pkg::IPA_INDEX_BITS
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] vertex_index;
    logic                  last_in_batch;

    modport source (output valid, output vertex_index, output last_in_batch, input ready);
    modport sink   (input valid, input vertex_index, input last_in_batch, output ready);
endinterface

/* sv/ipa_prim_if.sv */
// Primitive output channel: valid/ready plus one assembled primitive word.
// Depends on ipa_pkg for the default index width.
interface ipa_prim_if #(
    parameter int unsigned INDEX_BITS = ipa_pkg::IPA_INDEX_BITS
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] first_vertex;
    logic [INDEX_BITS-1:0] second_vertex;
    logic [INDEX_BITS-1:0] third_vertex;
    logic                  is_line;
    logic                  index_error;

    modport source (output valid, output first_vertex, output second_vertex,
                    output third_vertex, output is_line, output index_error, input ready);
    modport sink   (input valid, input first_vertex, input second_vertex,
                    input third_vertex, input is_line, input index_error, output ready);
endinterface

/* sv/index_primitive_assembler_top.sv */
// Index primitive assembler top level: batch state, range check, output skid stage.
// Depends on ipa_pkg, ipa_idx_if, ipa_prim_if and index_primitive_assembler_top_assert.svh.
//
// Takes one vertex index word per clock while input ready is high and emits zero or one
// primitive word per index (triangle list/fan/strip, line list/strip). Throughput is one
// index per cycle while the skid word is free; the primitive that an index completes is
// registered in the output register, or in the skid word while the output stalls.
// An output register backed by a one-word skid stage keeps input flowing while the output
// is stalled until a second primitive word is waiting; input ready drops only while the
// skid word is occupied. Write configuration only while no word is in flight.
module index_primitive_assembler_top #(
    parameter int unsigned INDEX_BITS = ipa_pkg::IPA_INDEX_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  ipa_pkg::t_cfg_idx        i_cfg_idx,
    input  logic [INDEX_BITS:0]      i_cfg_data,
    ipa_idx_if.sink                  i_idx_ch,
    ipa_prim_if.source               o_prim_ch
);
    import ipa_pkg::*;

    `include "index_primitive_assembler_top_assert.svh"

    typedef logic [INDEX_BITS-1:0] t_index;

    typedef struct packed {
        t_index first_vertex;
        t_index second_vertex;
        t_index third_vertex;
        logic   is_line;
        logic   index_error;
    } t_prim;

    localparam logic [INDEX_BITS:0] VCOUNT_RESET = {1'b1, {INDEX_BITS{1'b0}}};

    t_topology           r_topology;
    logic [INDEX_BITS:0] r_vertex_count;

    t_index      r_hub, r_older, r_newer;
    t_index      n_hub, n_older, n_newer;
    logic [1:0]  r_phase, n_phase;
    logic        r_parity, n_parity;
    logic        r_batch_err, n_batch_err;

    t_prim       r_out, r_skid, res;
    logic        r_out_vld, r_skid_vld;
    logic        has_res, in_range, topo_line, in_acc, out_take;
    t_index      idx;

    assign idx       = i_idx_ch.vertex_index;
    assign in_acc    = i_idx_ch.valid && i_idx_ch.ready;
    assign out_take  = r_out_vld && o_prim_ch.ready;
    assign in_range  = {1'b0, idx} < r_vertex_count;
    assign topo_line = (r_topology == TOPO_LINE_LIST) || (r_topology == TOPO_LINE_STRIP);

    always_comb begin
        n_hub       = r_hub;
        n_older     = r_older;
        n_newer     = r_newer;
        n_phase     = r_phase;
        n_parity    = r_parity;
        n_batch_err = r_batch_err;
        has_res     = 1'b0;
        res         = '0;
        if (!in_range) begin
            n_batch_err       = 1'b1;
            has_res           = 1'b1;
            res.first_vertex  = idx;
            res.is_line       = topo_line;
            res.index_error   = 1'b1;
        end else begin
            case (r_topology)
                TOPO_TRI_LIST, TOPO_TRI_FAN, TOPO_TRI_STRIP: begin
                    if (r_phase == 2'd0) begin
                        if (r_topology == TOPO_TRI_FAN) begin
                            n_hub = idx;
                        end else begin
                            n_older = idx;
                        end
                        n_phase = 2'd1;
                    end else if (r_phase == 2'd1) begin
                        n_newer = idx;
                        n_phase = 2'd2;
                    end else begin
                        has_res          = 1'b1;
                        res.third_vertex = idx;
                        res.index_error  = r_batch_err;
                        if (r_topology == TOPO_TRI_LIST) begin
                            res.first_vertex  = r_older;
                            res.second_vertex = r_newer;
                            n_phase           = 2'd0;
                        end else if (r_topology == TOPO_TRI_FAN) begin
                            res.first_vertex  = r_hub;
                            res.second_vertex = r_newer;
                            n_newer           = idx;
                            n_phase           = 2'd2;
                        end else begin
                            res.first_vertex  = r_parity ? r_newer : r_older;
                            res.second_vertex = r_parity ? r_older : r_newer;
                            n_older           = r_newer;
                            n_newer           = idx;
                            n_parity          = ~r_parity;
                            n_phase           = 2'd2;
                        end
                    end
                end
                TOPO_LINE_LIST: begin
                    if (r_phase == 2'd0) begin
                        n_older = idx;
                        n_phase = 2'd1;
                    end else begin
                        has_res           = 1'b1;
                        res.first_vertex  = r_older;
                        res.second_vertex = idx;
                        res.is_line       = 1'b1;
                        res.index_error   = r_batch_err;
                        n_phase           = 2'd0;
                    end
                end
                TOPO_LINE_STRIP: begin
                    if (r_phase != 2'd0) begin
                        has_res           = 1'b1;
                        res.first_vertex  = r_newer;
                        res.second_vertex = idx;
                        res.is_line       = 1'b1;
                        res.index_error   = r_batch_err;
                    end
                    n_newer = idx;
                    n_phase = 2'd1;
                end
                default: begin
                end
            endcase
        end
        if (i_idx_ch.last_in_batch) begin
            n_hub       = '0;
            n_older     = '0;
            n_newer     = '0;
            n_phase     = 2'd0;
            n_parity    = 1'b0;
            n_batch_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topology     <= TOPO_TRI_LIST;
            r_vertex_count <= VCOUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOPOLOGY:     r_topology     <= i_cfg_data[TOPO_BITS-1:0];
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hub       <= '0;
            r_older     <= '0;
            r_newer     <= '0;
            r_phase     <= 2'd0;
            r_parity    <= 1'b0;
            r_batch_err <= 1'b0;
        end else if (in_acc) begin
            r_hub       <= n_hub;
            r_older     <= n_older;
            r_newer     <= n_newer;
            r_phase     <= n_phase;
            r_parity    <= n_parity;
            r_batch_err <= n_batch_err;
        end
    end

    // output register plus one skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || out_take) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= in_acc && has_res;
            end
        end else if (in_acc && has_res) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || out_take) begin
            r_out <= r_skid_vld ? r_skid : res;
        end
        if (!r_skid_vld) begin
            r_skid <= res;
        end
    end

    assign i_idx_ch.ready          = !r_skid_vld;
    assign o_prim_ch.valid         = r_out_vld;
    assign o_prim_ch.first_vertex  = r_out.first_vertex;
    assign o_prim_ch.second_vertex = r_out.second_vertex;
    assign o_prim_ch.third_vertex  = r_out.third_vertex;
    assign o_prim_ch.is_line       = r_out.is_line;
    assign o_prim_ch.index_error   = r_out.index_error;

    `IPA_ASSERT_NEVER(a_skid_needs_out, i_clk, i_rst_n, r_skid_vld && !r_out_vld,
        "skid word held while output register empty")
    `IPA_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n,
        i_rst_n && in_acc && i_idx_ch.last_in_batch,
        r_phase == 2'd0 && !r_batch_err && !r_parity,
        "batch state not cleared after last index")
    `IPA_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n,
        i_rst_n && in_acc && !in_range && !i_idx_ch.last_in_batch,
        r_batch_err,
        "out-of-range index did not set batch error")
    `IPA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        i_rst_n && r_out_vld && !o_prim_ch.ready,
        r_out_vld && $stable(r_out),
        "stalled output word changed")

endmodule

/* tb/tb_top.sv */
// Self-checking bench for index_primitive_assembler_top: drives index words, predicts
// the primitive words in SystemVerilog and checks each one as it arrives.
// Depends on ipa_pkg, ipa_idx_if, ipa_prim_if and the assembler top level.
module tb_top;
    import ipa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IB            = IPA_INDEX_BITS;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [IB-1:0] first_vertex;
        logic [IB-1:0] second_vertex;
        logic [IB-1:0] third_vertex;
        logic          is_line;
        logic          index_error;
    } prim_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          cfg_we;
    t_cfg_idx      cfg_idx;
    logic [IB:0]   cfg_data;

    ipa_idx_if  idx_ch ();
    ipa_prim_if prim_ch ();

    index_primitive_assembler_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_idx_ch   (idx_ch),
        .o_prim_ch  (prim_ch)
    );

    always #4 i_clk = ~i_clk;

    // assembler mirror
    t_topology     topo_cfg;
    logic [IB:0]   vcount_cfg;
    logic [IB-1:0] hub_idx, older_idx, newer_idx;
    logic [1:0]    gathered;
    logic          odd_tri;
    logic          sticky_err;

    prim_t awaited_prims[$];

    int  fail_count   = 0;
    int  words_sent   = 0;
    int  random_sent  = 0;
    int  prims_seen   = 0;
    int  cfg_writes   = 0;
    int  cycle_count  = 0;
    bit  idle_off     = 1'b0;

    function automatic int draw_gap();
        return idle_off ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void clear_assembly();
        hub_idx    = '0;
        older_idx  = '0;
        newer_idx  = '0;
        gathered   = '0;
        odd_tri    = 1'b0;
        sticky_err = 1'b0;
    endfunction

    function automatic void assemble_index(input logic [IB-1:0] idx, input logic last);
        prim_t p;
        logic  emit;
        emit            = 1'b0;
        p               = '0;
        p.is_line       = (topo_cfg == TOPO_LINE_LIST) || (topo_cfg == TOPO_LINE_STRIP);
        p.index_error   = sticky_err;
        if ({1'b0, idx} >= vcount_cfg) begin
            sticky_err      = 1'b1;
            p.first_vertex  = idx;
            p.index_error   = 1'b1;
            emit            = 1'b1;
        end else begin
            case (topo_cfg)
                TOPO_TRI_LIST, TOPO_TRI_FAN, TOPO_TRI_STRIP: begin
                    if (gathered == 2'd0) begin
                        if (topo_cfg == TOPO_TRI_FAN) hub_idx = idx;
                        else older_idx = idx;
                        gathered = 2'd1;
                    end else if (gathered == 2'd1) begin
                        newer_idx = idx;
                        gathered  = 2'd2;
                    end else begin
                        emit            = 1'b1;
                        p.third_vertex  = idx;
                        if (topo_cfg == TOPO_TRI_LIST) begin
                            p.first_vertex  = older_idx;
                            p.second_vertex = newer_idx;
                            gathered        = 2'd0;
                        end else if (topo_cfg == TOPO_TRI_FAN) begin
                            p.first_vertex  = hub_idx;
                            p.second_vertex = newer_idx;
                            newer_idx       = idx;
                            gathered        = 2'd2;
                        end else begin
                            // odd strip triangles swap their leading pair
                            p.first_vertex  = odd_tri ? newer_idx : older_idx;
                            p.second_vertex = odd_tri ? older_idx : newer_idx;
                            older_idx       = newer_idx;
                            newer_idx       = idx;
                            odd_tri         = ~odd_tri;
                            gathered        = 2'd2;
                        end
                    end
                end
                TOPO_LINE_LIST: begin
                    if (gathered == 2'd0) begin
                        older_idx = idx;
                        gathered  = 2'd1;
                    end else begin
                        emit            = 1'b1;
                        p.first_vertex  = older_idx;
                        p.second_vertex = idx;
                        gathered        = 2'd0;
                    end
                end
                TOPO_LINE_STRIP: begin
                    if (gathered != 2'd0) begin
                        emit            = 1'b1;
                        p.first_vertex  = newer_idx;
                        p.second_vertex = idx;
                    end
                    newer_idx = idx;
                    gathered  = 2'd1;
                end
                default: ;
            endcase
        end
        if (emit) awaited_prims.push_back(p);
        if (last) clear_assembly();
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // primitive word checker
    always @(posedge i_clk) begin
        prim_t want;
        if (i_rst_n && prim_ch.valid && prim_ch.ready) begin
            prims_seen++;
            if (awaited_prims.size() == 0) begin
                $error("primitive word with none expected: %0h %0h %0h",
                       prim_ch.first_vertex, prim_ch.second_vertex, prim_ch.third_vertex);
                fail_count++;
            end else begin
                want = awaited_prims.pop_front();
                check_field("first_vertex", want.first_vertex, prim_ch.first_vertex);
                check_field("second_vertex", want.second_vertex, prim_ch.second_vertex);
                check_field("third_vertex", want.third_vertex, prim_ch.third_vertex);
                check_field("is_line", want.is_line, prim_ch.is_line);
                check_field("index_error", want.index_error, prim_ch.index_error);
            end
        end
    end

    // output back-pressure
    initial begin
        int stall;
        prim_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                prim_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            prim_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(prim_ch.valid && prim_ch.ready));
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    task automatic send_index(input logic [IB-1:0] idx, input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            idx_ch.valid         <= 1'b0;
            idx_ch.vertex_index  <= IB'($urandom);
            idx_ch.last_in_batch <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        idx_ch.valid         <= 1'b1;
        idx_ch.vertex_index  <= idx;
        idx_ch.last_in_batch <= last;
        do @(posedge i_clk); while (!idx_ch.ready);
        assemble_index(idx, last);
        words_sent++;
    endtask

    // drop valid, drain expectations, then let in-flight words finish
    task automatic settle_block();
        idx_ch.valid <= 1'b0;
        while (awaited_prims.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx which, input logic [IB:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= which;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (which == CFG_TOPOLOGY) topo_cfg = t_topology'(value);
        else vcount_cfg = value;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input t_topology topo, input logic [IB:0] vcount);
        settle_block();
        write_reg(CFG_TOPOLOGY, (IB + 1)'(topo));
        write_reg(CFG_VERTEX_COUNT, vcount);
    endtask

    // reset values: triangle list, all 16-bit indices in range; tail dropped
    task automatic test_reset_defaults();
        send_index(16'hFFFF, 1'b0);
        send_index(16'h0000, 1'b0);
        send_index(16'h8000, 1'b0);
        send_index(16'h1234, 1'b1);
    endtask

    task automatic test_each_topology();
        set_mode(TOPO_TRI_FAN, 17'h10000);
        send_index(16'd7, 1'b0);
        send_index(16'd1, 1'b0);
        send_index(16'd2, 1'b0);
        send_index(16'd3, 1'b1);
        settle_block();
        write_reg(CFG_TOPOLOGY, (IB + 1)'(TOPO_TRI_STRIP));
        send_index(16'h0101, 1'b0);
        send_index(16'h0202, 1'b0);
        send_index(16'h0303, 1'b0);
        send_index(16'h0404, 1'b1);
        set_mode(TOPO_LINE_LIST, 17'h1FFFF);
        send_index(16'h5555, 1'b0);
        send_index(16'hAAAA, 1'b0);
        send_index(16'hFFFF, 1'b1);
        settle_block();
        write_reg(CFG_TOPOLOGY, (IB + 1)'(TOPO_LINE_STRIP));
        send_index(16'd10, 1'b0);
        send_index(16'd11, 1'b0);
        send_index(16'd12, 1'b1);
    endtask

    // bad index at the boundary, sticky flag on the following triangle
    task automatic test_index_errors();
        set_mode(TOPO_TRI_LIST, 17'h100);
        send_index(16'd5, 1'b0);
        send_index(16'h100, 1'b0);
        send_index(16'd6, 1'b0);
        send_index(16'hFF, 1'b1);
        set_mode(TOPO_LINE_STRIP, 17'h0);
        send_index(16'h0000, 1'b1);
    endtask

    task automatic test_unknown_topology();
        set_mode(t_topology'(7), 17'h10);
        send_index(16'h000F, 1'b0);
        send_index(16'h0010, 1'b1);
    endtask

    // open strip batch continues as a line list after the switch
    task automatic test_topology_switch_mid_batch();
        set_mode(TOPO_TRI_STRIP, 17'h10000);
        send_index(16'd40, 1'b0);
        send_index(16'd41, 1'b0);
        settle_block();
        write_reg(CFG_TOPOLOGY, (IB + 1)'(TOPO_LINE_LIST));
        send_index(16'd42, 1'b1);
    endtask

    function automatic logic [IB-1:0] pick_index(input logic [IB:0] vcount);
        if (vcount == 0 || vcount > 17'h10000) return IB'($urandom);
        if ($urandom_range(0, 9) == 0 && vcount <= 17'hFFFF)
            return IB'($urandom_range(int'(vcount), 16'hFFFF));
        return IB'($urandom_range(0, int'(vcount) - 1));
    endfunction

    task automatic test_random_batches();
        int          round_no;
        int          n_words;
        int          sel;
        t_topology   topo;
        logic [IB:0] vcount;
        logic        close_at_end;
        logic        last;
        round_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            topo = (round_no < 8) ? t_topology'(round_no)
                 : (sel < 18) ? t_topology'(sel % 5) : t_topology'($urandom_range(5, 7));
            case ((round_no < 4) ? round_no : $urandom_range(0, 7))
                0:       vcount = 17'h1FFFF;
                1:       vcount = 17'h0FFFF;
                2:       vcount = 17'h00001;
                3:       vcount = 17'h10000;
                4:       vcount = 17'h00000;
                5, 6:    vcount = (IB + 1)'($urandom_range(2, 64));
                default: vcount = (IB + 1)'($urandom_range(0, 17'h1FFFF));
            endcase
            set_mode(topo, vcount);
            idle_off     = ($urandom_range(0, 4) == 0);
            n_words      = $urandom_range(40, 90);
            close_at_end = $urandom_range(0, 1);
            for (int k = 0; k < n_words; k++) begin
                last = ($urandom_range(0, 5) == 0) || (close_at_end && k == n_words - 1);
                send_index(pick_index(vcount), last);
                random_sent++;
            end
            round_no++;
        end
        idle_off = 1'b0;
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_TOPOLOGY;
        cfg_data             <= '0;
        idx_ch.valid         <= 1'b0;
        idx_ch.vertex_index  <= '0;
        idx_ch.last_in_batch <= 1'b0;
        topo_cfg   = TOPO_TRI_LIST;
        vcount_cfg = 17'h10000;
        clear_assembly();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_each_topology();
        test_index_errors();
        test_unknown_topology();
        test_topology_switch_mid_batch();
        test_random_batches();

        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d index words (%0d random), checked %0d primitive words",
                 words_sent, random_sent, prims_seen);
        $display("config writes: %0d, all topologies incl. unknown, vertex counts 0..131071",
                 cfg_writes);
        if (fail_count == 0 && awaited_prims.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* index_primitive_assembler_top.f */
+incdir+sv
sv/ipa_pkg.sv
sv/ipa_idx_if.sv
sv/ipa_prim_if.sv
sv/index_primitive_assembler_top.sv
tb/tb_top.sv
